>>> rtl/rwc_pkg.sv
// Shared widths, types and constants for the replay window check.
`timescale 1ns / 1ps

package rwc_pkg;

    localparam int SEQ_BITS  = 12;
    localparam int WIN_SIZE  = 32;
    localparam int WIN_IDX_W = $clog2(WIN_SIZE);
    localparam int CNT_W     = 32;

    typedef logic [SEQ_BITS-1:0] seq_t;
    typedef logic [WIN_SIZE-1:0] win_t;
    typedef logic [CNT_W-1:0]    cnt_t;

    typedef enum logic
    {
        STATUS_ACCEPT = 1'b0,
        STATUS_REJECT = 1'b1
    } status_t;

    typedef struct packed
    {
        status_t status;
        cnt_t    accepted_total;
        cnt_t    rejected_total;
    } verdict_t;

endpackage

>>> rtl/replay_window_check_core.sv
// Top level of the anti-replay sliding window check.
//
//  channel | handshake                      | payload
//  --------+--------------------------------+-----------------------------------------
//  in      | in_valid / in_stall            | sequence_req[11:0]
//  out     | out_valid / out_stall          | status, accepted_total, rejected_total
//
// One beat per cycle while the output is not stalled: input register, window check, result register.
// An input beat passes from the input register through the window check into the result register.
// Reset clears the window, the newest number, the start flag and both counters.
// A stalled output holds its beat; the input register stalls only when it is
// full and the result register cannot drain.
`timescale 1ns / 1ps

module replay_window_check_core
    import rwc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [11:0] sequence_req,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        status,
    output logic [31:0] accepted_total,
    output logic [31:0] rejected_total
);

    logic     valid_reg, valid_next;
    seq_t     seq_reg;
    logic     advance;
    logic     in_take;
    logic     fire;
    verdict_t verdict;

    assign advance  = !out_valid || !out_stall;
    assign fire     = valid_reg && advance;
    assign in_stall = valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        if (in_take)
            valid_next = 1'b1;
        else if (advance)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            seq_reg <= seq_t'(sequence_req);
    end

    rwc_window u_window
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (fire),
        .seq     (seq_reg),
        .verdict (verdict)
    );

    rwc_result u_result
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .load           (fire),
        .verdict        (verdict),
        .out_stall      (out_stall),
        .out_valid      (out_valid),
        .status         (status),
        .accepted_total (accepted_total),
        .rejected_total (rejected_total)
    );

endmodule

>>> rtl/rwc_window.sv
// Anti-replay window state, decision logic and running counters.
`timescale 1ns / 1ps

module rwc_window
    import rwc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     fire,
    input  seq_t     seq,
    output verdict_t verdict
);

    logic started_reg, started_next;
    seq_t newest_reg, newest_next;
    win_t seen_reg, seen_next;
    cnt_t acc_reg, acc_next;
    cnt_t rej_reg, rej_next;

    seq_t diff;
    seq_t offset;
    logic forward;
    logic ok;

    always_comb
    begin
        diff    = seq - newest_reg;
        offset  = seq_t'(0) - diff;
        forward = (diff != seq_t'(0)) && !diff[SEQ_BITS-1];

        started_next = started_reg;
        newest_next  = newest_reg;
        seen_next    = seen_reg;
        ok           = 1'b0;

        if (!started_reg)
        begin
            started_next = 1'b1;
            newest_next  = seq;
            seen_next    = win_t'(1);
            ok           = 1'b1;
        end
        else if (forward)
        begin
            if (diff >= seq_t'(WIN_SIZE))
                seen_next = win_t'(1);
            else
                seen_next = (seen_reg << diff[WIN_IDX_W-1:0]) | win_t'(1);
            newest_next = seq;
            ok          = 1'b1;
        end
        else if (offset < seq_t'(WIN_SIZE))
        begin
            if (!seen_reg[offset[WIN_IDX_W-1:0]])
            begin
                seen_next = seen_reg | (win_t'(1) << offset[WIN_IDX_W-1:0]);
                ok        = 1'b1;
            end
        end

        acc_next = ok ? acc_reg + cnt_t'(1) : acc_reg;
        rej_next = ok ? rej_reg : rej_reg + cnt_t'(1);

        verdict.status         = ok ? STATUS_ACCEPT : STATUS_REJECT;
        verdict.accepted_total = acc_next;
        verdict.rejected_total = rej_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg <= 1'b0;
            newest_reg  <= '0;
            seen_reg    <= '0;
            acc_reg     <= '0;
            rej_reg     <= '0;
        end
        else if (fire)
        begin
            started_reg <= started_next;
            newest_reg  <= newest_next;
            seen_reg    <= seen_next;
            acc_reg     <= acc_next;
            rej_reg     <= rej_next;
        end
    end

endmodule

>>> rtl/rwc_result.sv
// Result register holding one beat for the output channel.
`timescale 1ns / 1ps

module rwc_result
    import rwc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     load,
    input  verdict_t verdict,
    input  logic     out_stall,
    output logic     out_valid,
    output logic     status,
    output cnt_t     accepted_total,
    output cnt_t     rejected_total
);

    logic     valid_reg, valid_next;
    verdict_t data_reg;

    always_comb
    begin
        if (load)
            valid_next = 1'b1;
        else if (!out_stall)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= verdict;
    end

    assign out_valid      = valid_reg;
    assign status         = data_reg.status;
    assign accepted_total = data_reg.accepted_total;
    assign rejected_total = data_reg.rejected_total;

endmodule
